// ===== hw/rtl/ccfc_pkg.sv =====
package ccfc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int NUM_LETTERS = 26;
    localparam int LETTER_W    = $clog2(NUM_LETTERS);
    localparam int CHAR_W      = 8;
    localparam int KEY_W       = 5;
    localparam int RKEY_W      = 6;
    localparam int OP_W        = 2;

    localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UA = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ = 8'h5A;

    localparam logic [LETTER_W-1:0]    E_INDEX   = LETTER_W'(4);
    localparam logic [KEY_W-1:0]       KEY_RESET = KEY_W'(3);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_ENCRYPT = 2'd0,
        OP_TALLY   = 2'd1,
        OP_DECRYPT = 2'd2
    } op_t;

endpackage

// ===== hw/rtl/caesar_cipher_frequency_crack_top.sv =====
// Caesar cipher byte engine with frequency-analysis key recovery.
//
// Input channel: drive op and char_in with start high; the beat is taken at
// a rising edge where start is high and busy is low. busy rises for one
// cycle after each accepted beat.
// Result channel: done pulses for exactly one cycle with char_out and
// recovered_key. The receiver cannot stall; a result not sampled in that
// cycle is gone.
// Configuration: cfg_we with cfg_wdata writes shift_key at a clock edge; write
// only while no beat is in flight.
// Timing: an accepted beat moves the block into the execute state, at whose
// end done is registered. A new beat may be started in the strobe cycle. The
// execute state serves the registered read of the letter-count memory (read
// on accept, then increment and write back).
// The most frequent letter is tracked incrementally next to the memory, so
// no scan of the histogram is needed on any op.
// Reset: the histogram reads as all zero (per-entry valid bits are
// cleared), the leading letter goes to 'a' and shift_key to 3.
module caesar_cipher_frequency_crack_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [ccfc_pkg::OP_W-1:0]             op,
    input  logic [ccfc_pkg::CHAR_W-1:0]           char_in,
    output logic                                  done,
    output logic [ccfc_pkg::CHAR_W-1:0]           char_out,
    output logic signed [ccfc_pkg::RKEY_W-1:0]    recovered_key,
    input  logic                                  cfg_we,
    input  logic [ccfc_pkg::KEY_W-1:0]            cfg_wdata
);
    import ccfc_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                     state_reg;
    op_t                        op_reg;
    logic [CHAR_W-1:0]          char_reg;
    logic [KEY_W-1:0]           shift_key_reg;
    logic [NUM_LETTERS-1:0]     letter_valid_reg;
    logic [COUNT_WIDTH-1:0]     rd_data_reg;
    logic [LETTER_W-1:0]        top_reg;
    logic [COUNT_WIDTH-1:0]     top_count_reg;
    logic                       done_reg;
    logic [CHAR_W-1:0]          char_out_reg;
    logic [RKEY_W-1:0]          key_reg;

    // Letter-count histogram with a registered read.
    logic [COUNT_WIDTH-1:0]     count_mem [NUM_LETTERS];

    logic                       accept;
    logic [LETTER_W-1:0]        in_idx;
    logic                       is_lower;
    logic                       is_upper;
    logic [LETTER_W-1:0]        idx;
    logic [KEY_W-1:0]           key_mod;
    logic [LETTER_W:0]          enc_sum;
    logic [LETTER_W:0]          dec_sum;
    logic [LETTER_W-1:0]        enc_idx;
    logic [LETTER_W-1:0]        dec_idx;
    logic [COUNT_WIDTH-1:0]     cur_count;
    logic [COUNT_WIDTH-1:0]     new_count;
    logic                       mem_we;
    logic [LETTER_W-1:0]        top_next;
    logic [COUNT_WIDTH-1:0]     top_count_next;
    logic [CHAR_W-1:0]          char_out_next;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // Only meaningful for lower-case bytes; other reads are discarded.
    assign in_idx = LETTER_W'(char_in - CH_LA);

    always_comb
    begin
        is_lower = (char_reg >= CH_LA) && (char_reg <= CH_LZ);
        is_upper = (char_reg >= CH_UA) && (char_reg <= CH_UZ);
        idx      = is_lower ? LETTER_W'(char_reg - CH_LA) : LETTER_W'(char_reg - CH_UA);

        // Reduce the key mod 26: it never reaches twice that.
        key_mod = (shift_key_reg >= KEY_W'(NUM_LETTERS))
                  ? (shift_key_reg - KEY_W'(NUM_LETTERS)) : shift_key_reg;

        enc_sum = {1'b0, idx} + (LETTER_W + 1)'(key_mod);
        enc_idx = (enc_sum >= (LETTER_W + 1)'(NUM_LETTERS))
                  ? LETTER_W'(enc_sum - (LETTER_W + 1)'(NUM_LETTERS))
                  : LETTER_W'(enc_sum);

        // Back shift by (top - 4); sum stays in 5..55, so at most two folds.
        dec_sum = {1'b0, idx} + (LETTER_W + 1)'(NUM_LETTERS) + {1'b0, E_INDEX}
                  - {1'b0, top_reg};
        if (dec_sum >= (LETTER_W + 1)'(2 * NUM_LETTERS))
            dec_idx = LETTER_W'(dec_sum - (LETTER_W + 1)'(2 * NUM_LETTERS));
        else if (dec_sum >= (LETTER_W + 1)'(NUM_LETTERS))
            dec_idx = LETTER_W'(dec_sum - (LETTER_W + 1)'(NUM_LETTERS));
        else
            dec_idx = LETTER_W'(dec_sum);

        // Entries never written read as zero.
        cur_count = letter_valid_reg[idx] ? rd_data_reg : '0;
        new_count = cur_count + COUNT_WIDTH'(1);

        mem_we         = 1'b0;
        top_next       = top_reg;
        top_count_next = top_count_reg;
        char_out_next  = char_reg;

        unique case (op_reg)
            OP_ENCRYPT:
            begin
                if (is_lower || is_upper)
                    char_out_next = CH_LA + CHAR_W'(enc_idx);
            end
            OP_TALLY:
            begin
                if (is_lower && (cur_count != COUNT_MAX))
                begin
                    mem_we = (state_reg == S_EXEC);
                    // Counts only grow, so the leader changes only to this
                    // letter: on a higher count, or on a tie at a lower index.
                    if (idx == top_reg)
                        top_count_next = new_count;
                    else if ((new_count > top_count_reg)
                             || ((new_count == top_count_reg) && (idx < top_reg)))
                    begin
                        top_next       = idx;
                        top_count_next = new_count;
                    end
                end
            end
            OP_DECRYPT:
            begin
                if (is_lower || is_upper)
                    char_out_next = CH_LA + CHAR_W'(dec_idx);
            end
            default:
            begin
                char_out_next = char_reg;
            end
        endcase
    end

    // Histogram memory: read on accept, write back in the execute cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= count_mem[in_idx];
        if (mem_we)
            count_mem[idx] <= new_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            done_reg         <= 1'b0;
            shift_key_reg    <= KEY_RESET;
            letter_valid_reg <= '0;
            top_reg          <= '0;
            top_count_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
                shift_key_reg <= cfg_wdata;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (mem_we)
                        letter_valid_reg[idx] <= 1'b1;
                    top_reg       <= top_next;
                    top_count_reg <= top_count_next;
                    done_reg      <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload: capture the beat, then the result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(op);
            char_reg <= char_in;
        end
        if (state_reg == S_EXEC)
        begin
            char_out_reg <= char_out_next;
            key_reg      <= RKEY_W'({1'b0, top_next}) - RKEY_W'(E_INDEX);
        end
    end

    assign done          = done_reg;
    assign char_out      = char_out_reg;
    assign recovered_key = key_reg;

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_EXEC))
        else $error("result strobe without an execute cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy && !done_reg))
        else $error("accepted beat did not raise busy");

    a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg < LETTER_W'(NUM_LETTERS))
        else $error("leading letter index out of range");

    a_top_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (top_count_reg >= $past(top_count_reg)))
        else $error("leading count decreased");

    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == S_EXEC) && (op_reg == OP_TALLY)))
        else $error("histogram write outside a tally execute cycle");

endmodule

// ===== test/caesar_cipher_frequency_crack_checker.sv =====
module caesar_cipher_frequency_crack_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic [ccfc_pkg::OP_W-1:0]             op,
    input  logic [ccfc_pkg::CHAR_W-1:0]           char_in,
    input  logic                                  done,
    input  logic [ccfc_pkg::CHAR_W-1:0]           char_out,
    input  logic signed [ccfc_pkg::RKEY_W-1:0]    recovered_key,
    input  logic                                  cfg_we,
    input  logic [ccfc_pkg::KEY_W-1:0]            cfg_wdata,
    output int unsigned                           mismatches,
    output int unsigned                           pending
);
    import ccfc_pkg::*;

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [RKEY_W-1:0] key;
    } cipher_result_t;

    cipher_result_t             awaited_results [$];
    logic [COUNT_WIDTH-1:0]     letter_tally [NUM_LETTERS];
    logic [KEY_W-1:0]           shift_copy;
    int unsigned                error_count;

    function automatic int leading_letter();
        int lead;
        lead = 0;
        for (int i = 1; i < NUM_LETTERS; i++)
            if (letter_tally[i] > letter_tally[lead])
                lead = i;
        return lead;
    endfunction

    // Apply one beat to the local histogram and return the byte and key it should give.
    function automatic cipher_result_t cipher_beat(logic [OP_W-1:0] o, logic [CHAR_W-1:0] c);
        cipher_result_t r;
        bit             lower;
        bit             upper;
        int             idx;
        lower = (c >= CH_LA) && (c <= CH_LZ);
        upper = (c >= CH_UA) && (c <= CH_UZ);
        idx   = lower ? int'(c - CH_LA) : int'(c - CH_UA);
        r.ch  = c;
        case (o)
            OP_ENCRYPT:
                if (lower || upper)
                    r.ch = CHAR_W'(int'(CH_LA)
                                   + (idx + int'(shift_copy) % NUM_LETTERS) % NUM_LETTERS);
            OP_TALLY:
                if (lower && letter_tally[idx] != COUNT_MAX)
                    letter_tally[idx] = letter_tally[idx] + 1'b1;
            OP_DECRYPT:
                if (lower || upper)
                    r.ch = CHAR_W'(int'(CH_LA) + (idx + NUM_LETTERS + int'(E_INDEX)
                                                  - leading_letter()) % NUM_LETTERS);
            default: ;
        endcase
        r.key = RKEY_W'(leading_letter() - int'(E_INDEX));
        return r;
    endfunction

    task automatic report(string msg);
        // count every mismatch, but keep the log short if things go badly wrong
        if (error_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        cipher_result_t want;
        if (!rst_n) begin
            awaited_results.delete();
            for (int i = 0; i < NUM_LETTERS; i++)
                letter_tally[i] = '0;
            shift_copy  = KEY_RESET;
            error_count = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else begin
            // retire the result first: a new beat may be taken in the strobe cycle
            if (done) begin
                if (awaited_results.size() == 0) begin
                    report($sformatf("result char_out=%02h with no beat in flight", char_out));
                end
                else begin
                    want = awaited_results.pop_front();
                    if (char_out !== want.ch)
                        report($sformatf("char_out got %02h want %02h", char_out, want.ch));
                    if (recovered_key !== want.key)
                        report($sformatf("recovered_key got %0d want %0d",
                                         recovered_key, $signed(want.key)));
                end
            end
            if (cfg_we)
                shift_copy = cfg_wdata;
            if (start && !busy)
                awaited_results.push_back(cipher_beat(op, char_in));
            mismatches <= error_count;
            pending    <= awaited_results.size();
        end
    end

endmodule

// ===== test/caesar_cipher_frequency_crack_top_tb.sv =====
module caesar_cipher_frequency_crack_top_tb;
    import ccfc_pkg::*;

    localparam int          CLK_HALF       = 5;
    localparam int          RESET_CYCLES   = 7;
    // The limit sits well above the slowest legal run (every beat followed by the longest gap).
    localparam int unsigned CYCLE_LIMIT    = 1_500_000;
    localparam int          RANDOM_BEATS   = 1700;
    localparam int          KEY_PHASES     = 7;
    // A run of tallies of one letter with no gaps between them.
    localparam int          BURST_BEATS    = 40;
    // The op field has one code with no operation behind it.
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     start     = 1'b0;
    logic [OP_W-1:0]          op        = OP_ENCRYPT;
    logic [CHAR_W-1:0]        char_in   = '0;
    logic                     cfg_we    = 1'b0;
    logic [KEY_W-1:0]         cfg_wdata = '0;
    logic                     busy;
    logic                     done;
    logic [CHAR_W-1:0]        char_out;
    logic signed [RKEY_W-1:0] recovered_key;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned beats_by_op [4];
    int unsigned key_writes = 0;
    int unsigned cycle_count = 0;

    always #CLK_HALF clk = ~clk;

    caesar_cipher_frequency_crack_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .char_in       (char_in),
        .done          (done),
        .char_out      (char_out),
        .recovered_key (recovered_key),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // The checker watches both channels and the key port, predicts, and compares.
    caesar_cipher_frequency_crack_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .char_in       (char_in),
        .done          (done),
        .char_out      (char_out),
        .recovered_key (recovered_key),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // Drop the run if it hangs; a missing strobe shows up here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("FAIL caesar_cipher_frequency_crack_top");
            $finish;
        end
    end

    // Mostly short gaps, some none, a few long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Bias toward one hot letter so that the histogram develops a clear leader.
    function automatic logic [CHAR_W-1:0] random_char(logic [LETTER_W-1:0] hot);
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return CHAR_W'(int'(CH_LA) + int'(hot));
        else if (r < 65)
            return CHAR_W'(int'(CH_LA) + $urandom_range(NUM_LETTERS - 1));
        else if (r < 80)
            return CHAR_W'(int'(CH_UA) + $urandom_range(NUM_LETTERS - 1));
        return CHAR_W'($urandom_range(255));
    endfunction

    function automatic logic [OP_W-1:0] random_op();
        int r;
        r = $urandom_range(99);
        if (r < 22)
            return OP_ENCRYPT;
        else if (r < 62)
            return OP_TALLY;
        else if (r < 94)
            return OP_DECRYPT;
        return OP_RESERVED;
    endfunction

    // Present one beat and hold it until the edge that takes it. With no gap, start stays high on
    // return so a back-to-back beat never lowers and raises it in the same step.
    task automatic send_beat(input logic [OP_W-1:0] o, input logic [CHAR_W-1:0] c,
                             input bit with_gaps);
        int gap;
        start   <= 1'b1;
        op      <= o;
        char_in <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        beats_by_op[o]++;
        gap = with_gaps ? gap_len() : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off the sender until every result in flight has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // The key register is only written with the block idle.
    task automatic write_key(input logic [KEY_W-1:0] k);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= k;
        @(posedge clk);
        cfg_we    <= 1'b0;
        key_writes++;
    endtask

    initial begin
        logic [KEY_W-1:0]    phase_keys [KEY_PHASES];
        logic [LETTER_W-1:0] hot;
        int                  phase_beats;
        int                  seg_left;
        bit                  seg_gaps;

        phase_keys = '{5'd26, 5'd0, 5'd1, 5'd25, 5'd27, 5'd31, 5'd0};
        phase_keys[KEY_PHASES-1] = KEY_W'($urandom_range(31));
        for (int i = 0; i < 4; i++)
            beats_by_op[i] = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats under the reset key. Decrypt on an empty histogram first:
        // every count ties, so 'a' leads and the key reads -4.
        send_beat(OP_DECRYPT, 8'h61, 1'b1);
        send_beat(OP_DECRYPT, 8'h5A, 1'b1);     // upper case folds, then shifts back
        send_beat(OP_ENCRYPT, 8'h61, 1'b1);
        send_beat(OP_ENCRYPT, 8'h7A, 1'b1);     // wraps past 'z'
        send_beat(OP_ENCRYPT, 8'h41, 1'b0);
        send_beat(OP_ENCRYPT, 8'h5A, 1'b0);
        // Non-letters, including the bytes just outside each letter range.
        send_beat(OP_ENCRYPT, 8'h00, 1'b1);
        send_beat(OP_ENCRYPT, 8'hFF, 1'b1);
        send_beat(OP_ENCRYPT, 8'h80, 1'b0);
        send_beat(OP_ENCRYPT, 8'h40, 1'b1);
        send_beat(OP_ENCRYPT, 8'h5B, 1'b1);
        send_beat(OP_ENCRYPT, 8'h60, 1'b0);
        send_beat(OP_ENCRYPT, 8'h7B, 1'b1);
        send_beat(OP_ENCRYPT, 8'h30, 1'b1);
        send_beat(OP_ENCRYPT, 8'h39, 1'b1);
        // Reserved op echoes and leaves state alone.
        send_beat(OP_RESERVED, 8'h6D, 1'b1);
        send_beat(OP_RESERVED, 8'h4D, 1'b0);
        // Upper case and digits are never counted.
        send_beat(OP_TALLY, 8'h43, 1'b1);
        send_beat(OP_TALLY, 8'h35, 1'b1);
        // 'x' then 'b' once each: a tie, so the lower index wins.
        send_beat(OP_TALLY, 8'h78, 1'b0);
        send_beat(OP_TALLY, 8'h62, 1'b1);
        send_beat(OP_DECRYPT, 8'h6B, 1'b1);
        // 'z' takes the lead: largest recovered key.
        send_beat(OP_TALLY, 8'h7A, 1'b0);
        send_beat(OP_TALLY, 8'h7A, 1'b1);
        send_beat(OP_DECRYPT, 8'h42, 1'b1);
        send_beat(OP_DECRYPT, 8'h23, 1'b1);

        // Random phases, one key setting each, the extremes and out-of-range codes
        // among them. Each key write drains the pipe first.
        for (int p = 0; p < KEY_PHASES; p++) begin
            write_key(phase_keys[p]);
            hot         = LETTER_W'($urandom_range(NUM_LETTERS - 1));
            phase_beats = RANDOM_BEATS / KEY_PHASES;
            seg_left    = 0;
            seg_gaps    = 1'b1;
            while (phase_beats > 0) begin
                // Alternate stretches with and without gaps.
                if (seg_left == 0) begin
                    seg_left = $urandom_range(20, 60);
                    seg_gaps = ($urandom_range(3) != 0);
                end
                send_beat(random_op(), random_char(hot), seg_gaps);
                seg_left--;
                phase_beats--;
                // Mid-phase, let everything in flight come back once.
                if (p == 3 && phase_beats == RANDOM_BEATS / KEY_PHASES / 2)
                    drain();
            end
        end

        // Tally one letter back to back, then decrypt against it.
        write_key(KEY_W'($urandom_range(31)));
        for (int i = 0; i < BURST_BEATS; i++)
            send_beat(OP_TALLY, 8'h71, 1'b0);
        send_beat(OP_DECRYPT, 8'h51, 1'b1);
        send_beat(OP_DECRYPT, 8'h65, 1'b1);
        for (int i = 0; i < 30; i++)
            send_beat(random_op(), random_char(LETTER_W'(0)), 1'b1);

        // Wait out the last results, then idle briefly as slack.
        drain();
        repeat (4) @(posedge clk);

        $display("covered %0d beats: %0d encrypt, %0d tally, %0d decrypt, %0d reserved op",
                 beats_by_op[0] + beats_by_op[1] + beats_by_op[2] + beats_by_op[3],
                 beats_by_op[OP_ENCRYPT], beats_by_op[OP_TALLY], beats_by_op[OP_DECRYPT],
                 beats_by_op[OP_RESERVED]);
        $display("%0d shift key writes (0, 1, 25, 26, 27, 31 among them), one tally burst",
                 key_writes);
        if (mismatches == 0 && pending == 0)
            $display("PASS caesar_cipher_frequency_crack_top");
        else
            $display("FAIL caesar_cipher_frequency_crack_top");
        $finish;
    end

endmodule
